// ===== design/bump_allocator_with_realloc_macros.svh =====
// Assertion macros of the bump allocator, used by the allocation engine.
`ifndef BUMP_ALLOCATOR_WITH_REALLOC_MACROS_SVH
`define BUMP_ALLOCATOR_WITH_REALLOC_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BPA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bump allocator check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bump allocator check failed");

`endif

// ===== design/bpa_pkg.sv =====
// Shared types and constants of the bump allocator.
`timescale 1ns / 1ps

package bpa_pkg;

  // Result status codes.
  typedef logic [2:0] status_t;
  localparam status_t STATUS_OK        = 3'd0;
  localparam status_t STATUS_NO_SPACE  = 3'd1;
  localparam status_t STATUS_FULL      = 3'd2;
  localparam status_t STATUS_NOT_FOUND = 3'd3;
  localparam status_t STATUS_ZERO_SIZE = 3'd4;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t CFG_BASE_ADDRESS = 2'd0;
  localparam cfg_index_t CFG_ARENA_SIZE   = 2'd1;

  // Reset value of the arena size register.
  localparam logic [31:0] ARENA_SIZE_RESET = 32'd65536;

  // Operation codes of the input item.
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_REALLOC = 1'b1;

  // Configuration register contents handed to the allocation engine.
  typedef struct packed {
    logic [31:0] base_address;
    logic [31:0] arena_size;
  } bpa_cfg_t;

endpackage

// ===== design/bpa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bpa_cfg.sv =====
// Configuration registers of the bump allocator: base address and arena size.
`timescale 1ns / 1ps

module bpa_cfg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  bpa_pkg::cfg_index_t   cfg_index,
  input  logic [31:0]           cfg_data,
  output bpa_pkg::bpa_cfg_t     cfg
);

  import bpa_pkg::*;

  // Writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Register decode; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address <= '0;
      cfg.arena_size   <= ARENA_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_ADDRESS: cfg.base_address <= cfg_data;
        CFG_ARENA_SIZE:   cfg.arena_size   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/bpa_engine.sv =====
// Allocation engine: request sequencer, record table scan and result register.
`timescale 1ns / 1ps
`include "bump_allocator_with_realloc_macros.svh"

module bpa_engine #(
  parameter int RECORDS   = 64,
  parameter int ADDR_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bpa_pkg::bpa_cfg_t         cfg,
  // Request channel.
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      op,
  input  logic [31:0]               req_size,
  input  logic [31:0]               old_addr,
  input  logic                      old_is_null,
  // Result channel.
  output logic                      out_valid,
  input  logic                      out_stall,
  output bpa_pkg::status_t          out_status,
  output logic [31:0]               out_block_addr,
  output logic                      out_copy_needed,
  output logic [31:0]               out_copy_from,
  output logic [31:0]               out_copy_len,
  // Record table RAM.
  output logic                      mem_we,
  output logic [(RECORDS > 1 ? $clog2(RECORDS) : 1)-1:0] mem_waddr,
  output logic [(ADDR_BITS > 32 ? 32 : ADDR_BITS)+31:0]  mem_wdata,
  output logic [(RECORDS > 1 ? $clog2(RECORDS) : 1)-1:0] mem_raddr,
  input  logic [(ADDR_BITS > 32 ? 32 : ADDR_BITS)+31:0]  mem_rdata
);

  import bpa_pkg::*;

  localparam int AddrW = (ADDR_BITS > 32) ? 32 : ADDR_BITS;
  localparam int IdxW  = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int CntW  = $clog2(RECORDS + 1);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_DISPATCH = 5'b00010,
    ST_SEARCH   = 5'b00100,
    ST_CHECK    = 5'b01000,
    ST_FINISH   = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    JOB_ALLOC    = 2'd0,
    JOB_ZERO     = 2'd1,
    JOB_NOTFOUND = 2'd2,
    JOB_REALLOC  = 2'd3
  } job_t;

  // Control state.
  state_t            state;
  logic [31:0]       free_offset;
  logic [CntW-1:0]   count;

  // Per-request working registers.
  logic              op_q;
  logic              null_q;
  logic [31:0]       size_q;
  logic [AddrW-1:0]  old_q;
  job_t              job;
  logic [AddrW-1:0]  free_addr_q;
  logic [32:0]       sum_q;
  logic              fit_q;
  logic [IdxW-1:0]   data_idx;
  logic [IdxW-1:0]   hit_idx;
  logic [31:0]       old_size_q;
  logic              inplace_ok;
  logic [31:0]       inplace_off;
  logic [31:0]       copy_len_q;

  // Table entry fields as read back.
  logic [AddrW-1:0]  rd_addr_field;
  logic [31:0]       rd_size_field;
  logic              rd_match;
  logic              scan_last;

  // Check stage arithmetic.
  logic [31:0]       end_sum;
  logic [32:0]       shrink_diff;
  logic              end_match;

  // Finish stage decision.
  logic              out_free;
  logic              fin;
  status_t           res_status;
  logic [31:0]       res_addr;
  logic              res_copy;
  logic [31:0]       res_from;
  logic [31:0]       res_len;
  logic              res_we;
  logic [IdxW-1:0]   res_idx;
  logic [AddrW-1:0]  res_rec_addr;
  logic              res_off_we;
  logic [31:0]       res_off;

  assign in_stall = (state != ST_IDLE);

  assign rd_addr_field = mem_rdata[AddrW+31:32];
  assign rd_size_field = mem_rdata[31:0];
  assign rd_match      = (rd_addr_field == old_q);
  assign scan_last     = ((CntW'(data_idx) + CntW'(1)) == count);

  // Scan reads: entry 0 from dispatch, then one entry ahead each search cycle.
  always_comb begin
    mem_raddr = '0;
    if (state == ST_SEARCH) begin
      mem_raddr = data_idx + IdxW'(1);
    end
  end

  // In-place resize arithmetic on the matched record.
  assign end_sum     = 32'(old_q) + old_size_q;
  assign end_match   = (end_sum[AddrW-1:0] == free_addr_q);
  assign shrink_diff = sum_q - {1'b0, old_size_q};

  // Result selection once the request is fully evaluated.
  assign out_free = !out_valid || !out_stall;
  assign fin      = (state == ST_FINISH) && out_free;

  always_comb begin
    res_status   = STATUS_OK;
    res_addr     = '0;
    res_copy     = 1'b0;
    res_from     = '0;
    res_len      = '0;
    res_we       = 1'b0;
    res_idx      = hit_idx;
    res_rec_addr = free_addr_q;
    res_off_we   = 1'b0;
    res_off      = sum_q[31:0];
    case (job)
      JOB_ALLOC: begin
        if (!fit_q) begin
          res_status = STATUS_NO_SPACE;
        end else if (count == CntW'(RECORDS)) begin
          res_status = STATUS_FULL;
        end else begin
          res_we     = 1'b1;
          res_idx    = count[IdxW-1:0];
          res_addr   = 32'(free_addr_q);
          res_off_we = 1'b1;
        end
      end
      JOB_ZERO:     res_status = STATUS_ZERO_SIZE;
      JOB_NOTFOUND: res_status = STATUS_NOT_FOUND;
      JOB_REALLOC: begin
        if (inplace_ok) begin
          res_we       = 1'b1;
          res_rec_addr = old_q;
          res_addr     = 32'(old_q);
          res_off_we   = 1'b1;
          res_off      = inplace_off;
        end else if (!fit_q) begin
          res_status = STATUS_NO_SPACE;
        end else begin
          res_we     = 1'b1;
          res_addr   = 32'(free_addr_q);
          res_copy   = 1'b1;
          res_from   = 32'(old_q);
          res_len    = copy_len_q;
          res_off_we = 1'b1;
        end
      end
      default: res_status = STATUS_OK;
    endcase
  end

  // Record table write-back.
  assign mem_we    = fin && res_we;
  assign mem_waddr = res_idx;
  assign mem_wdata = {res_rec_addr, size_q};

  // Sequencer and allocator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      free_offset <= '0;
      count       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            state <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          if (op_q == OP_ALLOC || null_q) begin
            state <= ST_FINISH;
          end else if (size_q == '0) begin
            state <= ST_FINISH;
          end else if (count == '0) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (rd_match) begin
            state <= ST_CHECK;
          end else if (scan_last) begin
            state <= ST_FINISH;
          end
        end
        ST_CHECK: state <= ST_FINISH;
        ST_FINISH: begin
          if (out_free) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
            if (res_off_we) begin
              free_offset <= res_off;
            end
            if (res_we && job == JOB_ALLOC) begin
              count <= count + CntW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Request payload and working registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_q   <= op;
      null_q <= old_is_null;
      size_q <= req_size;
      old_q  <= old_addr[AddrW-1:0];
    end
    if (state == ST_DISPATCH) begin
      free_addr_q <= AddrW'(cfg.base_address + free_offset);
      sum_q       <= {1'b0, free_offset} + {1'b0, size_q};
      fit_q       <= ({1'b0, free_offset} + {1'b0, size_q}) <= {1'b0, cfg.arena_size};
      data_idx    <= '0;
      if (op_q == OP_ALLOC || null_q) begin
        job <= JOB_ALLOC;
      end else if (size_q == '0) begin
        job <= JOB_ZERO;
      end else if (count == '0) begin
        job <= JOB_NOTFOUND;
      end else begin
        job <= JOB_REALLOC;
      end
    end
    if (state == ST_SEARCH) begin
      data_idx <= data_idx + IdxW'(1);
      if (rd_match) begin
        hit_idx    <= data_idx;
        old_size_q <= rd_size_field;
      end else if (scan_last) begin
        job <= JOB_NOTFOUND;
      end
    end
    if (state == ST_CHECK) begin
      inplace_ok  <= end_match && (sum_q >= {1'b0, old_size_q})
                     && (shrink_diff <= {1'b0, cfg.arena_size});
      inplace_off <= shrink_diff[31:0];
      copy_len_q  <= (old_size_q < size_q) ? old_size_q : size_q;
    end
    if (fin) begin
      out_status      <= res_status;
      out_block_addr  <= res_addr;
      out_copy_needed <= res_copy;
      out_copy_from   <= res_from;
      out_copy_len    <= res_len;
    end
  end

  // Consistency checks.
  `BPA_ASSERT_IMPL(a_count_bound, 1'b1, count <= CntW'(RECORDS))
  `BPA_ASSERT_NEXT(a_accept_dispatch, in_valid && !in_stall && !rst, state == ST_DISPATCH)
  `BPA_ASSERT_NEXT(a_offset_hold, !mem_we && !rst, $stable(free_offset))
  `BPA_ASSERT_NEXT(a_write_reports_ok, mem_we && !rst, out_valid && out_status == STATUS_OK)
  `BPA_ASSERT_IMPL(a_copy_is_ok, out_valid && out_copy_needed, out_status == STATUS_OK)

endmodule

// ===== design/bump_allocator_with_realloc.sv =====
// Bump-pointer arena allocator with realloc. One request is processed at a
// time; in_stall stays high from acceptance until the result is loaded into
// the output register, and the next request may be accepted while that
// result still waits to be taken. Allocate requests, reallocate requests with
// a null old block and zero-size reallocates go from dispatch straight to the
// finish state. A reallocate with a real old block scans the record table one
// entry per cycle through the single read port of the table RAM, moves to a
// check state on the first matching record and then to finish, or goes to
// finish once all recorded blocks are scanned with no match. The table needs
// no clearing pass after reset: only entries below the record count are ever
// used. Configuration writes are accepted every cycle and must be issued only
// while no request is in flight.
`timescale 1ns / 1ps

module bump_allocator_with_realloc #(
  parameter int RECORDS   = 64,
  parameter int ADDR_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  bpa_pkg::cfg_index_t   cfg_index,
  input  logic [31:0]           cfg_data,
  // Request channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [31:0]           req_size,
  input  logic [31:0]           old_addr,
  input  logic                  old_is_null,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output bpa_pkg::status_t      status,
  output logic [31:0]           block_addr,
  output logic                  copy_needed,
  output logic [31:0]           copy_from,
  output logic [31:0]           copy_len
);

  import bpa_pkg::*;

  localparam int AddrW = (ADDR_BITS > 32) ? 32 : ADDR_BITS;
  localparam int IdxW  = (RECORDS > 1) ? $clog2(RECORDS) : 1;

  bpa_cfg_t          cfg;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [AddrW+31:0] mem_wdata;
  logic [IdxW-1:0]   mem_raddr;
  logic [AddrW+31:0] mem_rdata;

  // Configuration registers.
  bpa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Record table: address and size of each granted block.
  bpa_ram #(
    .WIDTH (AddrW + 32),
    .DEPTH (RECORDS)
  ) u_records (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Request sequencer and result register.
  bpa_engine #(
    .RECORDS   (RECORDS),
    .ADDR_BITS (ADDR_BITS)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op              (op),
    .req_size        (req_size),
    .old_addr        (old_addr),
    .old_is_null     (old_is_null),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (status),
    .out_block_addr  (block_addr),
    .out_copy_needed (copy_needed),
    .out_copy_from   (copy_from),
    .out_copy_len    (copy_len),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

endmodule
